### rtl/ecc_pkg.sv
// Shared constants and types for the edge set cycle checker.
package ecc_pkg;

  localparam int MAX_EDGES  = 8;
  localparam int SLOT_MAX   = 2 * MAX_EDGES;
  localparam int SLOT_W     = $clog2(SLOT_MAX);
  localparam int USED_W     = $clog2(SLOT_MAX + 1);
  localparam int EDGE_CNT_W = $clog2(MAX_EDGES + 1);
  localparam int ID_W       = 24;
  localparam int DEG_W      = 2;

  localparam logic [DEG_W-1:0] DEG_ZERO = DEG_W'(0);
  localparam logic [DEG_W-1:0] DEG_ONE  = DEG_W'(1);
  localparam logic [DEG_W-1:0] DEG_TWO  = DEG_W'(2);

  // One write command into the slot table per cycle, all at one address.
  typedef struct packed {
    logic [SLOT_W-1:0] addr;
    logic              id_we;
    logic [ID_W-1:0]   id;
    logic              deg_we;
    logic [DEG_W-1:0]  deg;
    logic              nb0_we;
    logic              nb1_we;
    logic [SLOT_W-1:0] nb;
    logic              vis_we;
    logic              clr_deg;
    logic              clr_vis;
  } ecc_wr_t;

  // Contents of the slot addressed by the single read port.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [DEG_W-1:0]  deg;
    logic [SLOT_W-1:0] nb0;
    logic [SLOT_W-1:0] nb1;
    logic              vis;
  } ecc_rd_t;

endpackage

### rtl/ecc_slots.sv
// Slot table: node id, degree, two neighbours and a visited mark per slot.
module ecc_slots (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [ecc_pkg::SLOT_W-1:0] raddr,
  input  ecc_pkg::ecc_wr_t           wr,
  output ecc_pkg::ecc_rd_t           rd
);

  logic [ecc_pkg::ID_W-1:0]   ids [ecc_pkg::SLOT_MAX];
  logic [ecc_pkg::DEG_W-1:0]  deg [ecc_pkg::SLOT_MAX];
  logic [ecc_pkg::SLOT_W-1:0] nb0 [ecc_pkg::SLOT_MAX];
  logic [ecc_pkg::SLOT_W-1:0] nb1 [ecc_pkg::SLOT_MAX];
  logic [ecc_pkg::SLOT_MAX-1:0] vis;

  always_ff @(posedge clk) begin
    if (wr.id_we) begin
      ids[wr.addr] <= wr.id;
    end
    if (wr.nb0_we) begin
      nb0[wr.addr] <= wr.nb;
    end
    if (wr.nb1_we) begin
      nb1[wr.addr] <= wr.nb;
    end
  end

  // Degrees drop back to zero for every new set.
  always_ff @(posedge clk) begin
    if (rst || wr.clr_deg) begin
      for (int i = 0; i < ecc_pkg::SLOT_MAX; i++) begin
        deg[i] <= ecc_pkg::DEG_ZERO;
      end
    end else if (wr.deg_we) begin
      deg[wr.addr] <= wr.deg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || wr.clr_vis) begin
      vis <= '0;
    end else if (wr.vis_we) begin
      vis[wr.addr] <= 1'b1;
    end
  end

  always_comb begin
    rd.id  = ids[raddr];
    rd.deg = deg[raddr];
    rd.nb0 = nb0[raddr];
    rd.nb1 = nb1[raddr];
    rd.vis = vis[raddr];
  end

endmodule

### rtl/ecc_seq.sv
// Sequencer: slot search, degree update and path trace over the slot table.
module ecc_seq (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [ecc_pkg::ID_W-1:0] end_a,
  input  logic [ecc_pkg::ID_W-1:0] end_b,
  input  logic                     last_edge,
  input  logic                     res_ready,
  input  ecc_pkg::ecc_rd_t         rd,
  output logic [ecc_pkg::SLOT_W-1:0] raddr,
  output ecc_pkg::ecc_wr_t         wr,
  output logic                     ready,
  output logic                     res_valid,
  output logic                     res_bit
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN_A   = 4'd1;
  localparam logic [3:0] S_SCAN_B   = 4'd2;
  localparam logic [3:0] S_DEG_A    = 4'd3;
  localparam logic [3:0] S_DEG_B    = 4'd4;
  localparam logic [3:0] S_WR_A     = 4'd5;
  localparam logic [3:0] S_WR_B     = 4'd6;
  localparam logic [3:0] S_EV_START = 4'd7;
  localparam logic [3:0] S_EV_ALL2  = 4'd8;
  localparam logic [3:0] S_EV_SCAN  = 4'd9;
  localparam logic [3:0] S_EV_WALK  = 4'd10;
  localparam logic [3:0] S_EV_FINAL = 4'd11;
  localparam logic [3:0] S_DONE     = 4'd12;

  logic [3:0]                       state, state_next;
  logic [ecc_pkg::USED_W-1:0]       idx, idx_next;
  logic [ecc_pkg::USED_W-1:0]       used, used_next;
  logic [ecc_pkg::EDGE_CNT_W-1:0]   edge_cnt, edge_cnt_next;
  logic                             ovf, ovf_next;
  logic [ecc_pkg::ID_W-1:0]         a_id, a_id_next;
  logic [ecc_pkg::ID_W-1:0]         b_id, b_id_next;
  logic                             last, last_next;
  logic [ecc_pkg::SLOT_W-1:0]       sa, sa_next;
  logic [ecc_pkg::SLOT_W-1:0]       sb, sb_next;
  logic [ecc_pkg::DEG_W-1:0]        da, da_next;
  logic [ecc_pkg::DEG_W-1:0]        db, db_next;
  logic [ecc_pkg::SLOT_W-1:0]       walk_start, walk_start_next;
  logic [ecc_pkg::SLOT_W-1:0]       walk_from, walk_from_next;
  logic [ecc_pkg::SLOT_W-1:0]       walk_at, walk_at_next;
  logic                             res, res_next;

  logic [ecc_pkg::ID_W-1:0] key;
  logic                     id_hit;
  logic                     same_slot;
  logic                     scan_end;
  logic [3:0]               edge_end;

  // The one id comparator, shared by both endpoint searches.
  assign key       = (state == S_SCAN_B) ? b_id : a_id;
  assign id_hit    = (rd.id == key);
  assign same_slot = (sa == sb);
  assign scan_end  = (idx == used);
  assign edge_end  = last ? S_EV_START : S_IDLE;

  assign ready     = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res_bit   = res;

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    used_next       = used;
    edge_cnt_next   = edge_cnt;
    ovf_next        = ovf;
    a_id_next       = a_id;
    b_id_next       = b_id;
    last_next       = last;
    sa_next         = sa;
    sb_next         = sb;
    da_next         = da;
    db_next         = db;
    walk_start_next = walk_start;
    walk_from_next  = walk_from;
    walk_at_next    = walk_at;
    res_next        = res;
    raddr           = idx[ecc_pkg::SLOT_W-1:0];
    wr              = '0;
    wr.addr         = sa;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          a_id_next = end_a;
          b_id_next = end_b;
          last_next = last_edge;
          if (!ovf && edge_cnt < ecc_pkg::EDGE_CNT_W'(ecc_pkg::MAX_EDGES)) begin
            edge_cnt_next = edge_cnt + ecc_pkg::EDGE_CNT_W'(1);
            idx_next      = '0;
            state_next    = S_SCAN_A;
          end else begin
            // drop the edge, but still close the set on its last mark
            state_next = last_edge ? S_EV_START : S_IDLE;
          end
        end
      end

      S_SCAN_A, S_SCAN_B: begin
        if (scan_end) begin
          // no match: take the next free slot
          wr.addr   = used[ecc_pkg::SLOT_W-1:0];
          wr.id_we  = 1'b1;
          wr.id     = key;
          used_next = used + ecc_pkg::USED_W'(1);
          idx_next  = '0;
          if (state == S_SCAN_A) begin
            sa_next    = used[ecc_pkg::SLOT_W-1:0];
            state_next = S_SCAN_B;
          end else begin
            sb_next    = used[ecc_pkg::SLOT_W-1:0];
            state_next = S_DEG_A;
          end
        end else if (id_hit) begin
          idx_next = '0;
          if (state == S_SCAN_A) begin
            sa_next    = idx[ecc_pkg::SLOT_W-1:0];
            state_next = S_SCAN_B;
          end else begin
            sb_next    = idx[ecc_pkg::SLOT_W-1:0];
            state_next = S_DEG_A;
          end
        end else begin
          idx_next = idx + ecc_pkg::USED_W'(1);
        end
      end

      S_DEG_A: begin
        raddr      = sa;
        da_next    = rd.deg;
        state_next = S_DEG_B;
      end

      S_DEG_B: begin
        raddr = sb;
        if (same_slot ? (rd.deg != ecc_pkg::DEG_ZERO)
                      : (da > ecc_pkg::DEG_ONE || rd.deg > ecc_pkg::DEG_ONE)) begin
          ovf_next   = 1'b1;
          state_next = edge_end;
        end else begin
          db_next    = rd.deg;
          state_next = S_WR_A;
        end
      end

      S_WR_A: begin
        wr.addr   = sa;
        wr.deg_we = 1'b1;
        if (same_slot) begin
          // self loop: the node is its own neighbour on both sides
          wr.nb0_we  = 1'b1;
          wr.nb1_we  = 1'b1;
          wr.nb      = sa;
          wr.deg     = ecc_pkg::DEG_TWO;
          state_next = edge_end;
        end else begin
          wr.nb0_we  = !da[0];
          wr.nb1_we  = da[0];
          wr.nb      = sb;
          wr.deg     = da + ecc_pkg::DEG_ONE;
          state_next = S_WR_B;
        end
      end

      S_WR_B: begin
        wr.addr    = sb;
        wr.deg_we  = 1'b1;
        wr.nb0_we  = !db[0];
        wr.nb1_we  = db[0];
        wr.nb      = sa;
        wr.deg     = db + ecc_pkg::DEG_ONE;
        state_next = edge_end;
      end

      S_EV_START: begin
        wr.clr_vis = 1'b1;
        idx_next   = '0;
        if (ovf) begin
          res_next   = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_EV_ALL2;
        end
      end

      S_EV_ALL2: begin
        if (scan_end) begin
          res_next   = 1'b1;
          state_next = S_DONE;
        end else if (rd.deg != ecc_pkg::DEG_TWO) begin
          idx_next   = '0;
          state_next = S_EV_SCAN;
        end else begin
          idx_next = idx + ecc_pkg::USED_W'(1);
        end
      end

      S_EV_SCAN: begin
        if (scan_end) begin
          idx_next   = '0;
          state_next = S_EV_FINAL;
        end else begin
          idx_next = idx + ecc_pkg::USED_W'(1);
          if (rd.deg == ecc_pkg::DEG_ONE && !rd.vis) begin
            // open a path trace at this unvisited end
            wr.addr         = idx[ecc_pkg::SLOT_W-1:0];
            wr.vis_we       = 1'b1;
            walk_start_next = idx[ecc_pkg::SLOT_W-1:0];
            walk_from_next  = idx[ecc_pkg::SLOT_W-1:0];
            walk_at_next    = rd.nb0;
            state_next      = S_EV_WALK;
          end
        end
      end

      S_EV_WALK: begin
        raddr     = walk_at;
        wr.addr   = walk_at;
        if (walk_at != walk_start && rd.deg == ecc_pkg::DEG_TWO && !rd.vis) begin
          wr.vis_we      = 1'b1;
          walk_at_next   = (rd.nb0 == walk_from) ? rd.nb1 : rd.nb0;
          walk_from_next = walk_at;
        end else if (walk_at == walk_start) begin
          res_next   = 1'b1;
          state_next = S_DONE;
        end else begin
          wr.vis_we  = 1'b1;
          state_next = S_EV_SCAN;
        end
      end

      S_EV_FINAL: begin
        if (scan_end) begin
          res_next   = 1'b0;
          state_next = S_DONE;
        end else if (rd.deg == ecc_pkg::DEG_TWO && !rd.vis) begin
          res_next   = 1'b1;
          state_next = S_DONE;
        end else begin
          idx_next = idx + ecc_pkg::USED_W'(1);
        end
      end

      S_DONE: begin
        if (res_ready) begin
          wr.clr_deg    = 1'b1;
          used_next     = '0;
          edge_cnt_next = '0;
          ovf_next      = 1'b0;
          state_next    = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      used     <= '0;
      edge_cnt <= '0;
      ovf      <= 1'b0;
    end else begin
      state    <= state_next;
      used     <= used_next;
      edge_cnt <= edge_cnt_next;
      ovf      <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    a_id       <= a_id_next;
    b_id       <= b_id_next;
    last       <= last_next;
    sa         <= sa_next;
    sb         <= sb_next;
    da         <= da_next;
    db         <= db_next;
    walk_start <= walk_start_next;
    walk_from  <= walk_from_next;
    walk_at    <= walk_at_next;
    res        <= res_next;
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= ecc_pkg::USED_W'(ecc_pkg::SLOT_MAX))
    else $error("slot count beyond table size");

  a_edge_bound: assert property (@(posedge clk) disable iff (rst)
    edge_cnt <= ecc_pkg::EDGE_CNT_W'(ecc_pkg::MAX_EDGES))
    else $error("edge count beyond limit");

  a_set_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && res_ready) |=> (used == '0 && edge_cnt == '0 && !ovf))
    else $error("set state not cleared after result");

  a_slots_per_edge: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (used <= {edge_cnt, 1'b0}))
    else $error("more slots than two per accepted edge");

endmodule

### rtl/edge_set_cycle_check.sv
// Top level of the edge set cycle checker with its result register.
//
//   channel  direction  handshake                  payload
//   edge     in         edge_valid / edge_stall    end_a, end_b, last_edge
//   result   out        result_valid / result_stall  cycle_found
//
// An accepted edge keeps the sequencer busy: a single id comparator searches the
// slot table a slot a cycle for each end, then degrees are read and written a slot
// a cycle. A dropped edge that is not the last leaves the sequencer ready. The last
// edge adds a path trace before the result word.
// Reset is synchronous and clears the set at once; no clearing pass. edge_stall is
// high while the sequencer is busy, which a waiting result word prolongs only once
// the next set reaches its own result.
module edge_set_cycle_check (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     edge_valid,
  output logic                     edge_stall,
  input  logic [ecc_pkg::ID_W-1:0] end_a,
  input  logic [ecc_pkg::ID_W-1:0] end_b,
  input  logic                     last_edge,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic                     cycle_found
);

  logic                       seq_ready;
  logic                       start;
  logic                       res_valid;
  logic                       res_bit;
  logic                       res_ready;
  logic [ecc_pkg::SLOT_W-1:0] raddr;
  ecc_pkg::ecc_wr_t           wr;
  ecc_pkg::ecc_rd_t           rd;

  assign edge_stall = !seq_ready;
  assign start      = edge_valid && seq_ready;
  assign res_ready  = !result_valid || !result_stall;

  ecc_slots u_slots (
    .clk   (clk),
    .rst   (rst),
    .raddr (raddr),
    .wr    (wr),
    .rd    (rd)
  );

  ecc_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .end_a     (end_a),
    .end_b     (end_b),
    .last_edge (last_edge),
    .res_ready (res_ready),
    .rd        (rd),
    .raddr     (raddr),
    .wr        (wr),
    .ready     (seq_ready),
    .res_valid (res_valid),
    .res_bit   (res_bit)
  );

  // hold the result word until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      cycle_found <= res_bit;
    end
  end

endmodule

### verif/tb_edge_set_cycle_check.sv
// Self-checking testbench for the edge set cycle checker.
module tb_edge_set_cycle_check;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT      = 500000;
  localparam int HOLD_START = 3000;
  localparam int HOLD_LEN   = 600;
  localparam int TAIL       = 150;

  typedef struct {
    logic [ecc_pkg::ID_W-1:0] a;
    logic [ecc_pkg::ID_W-1:0] b;
    logic                     last;
    logic                     hold;
  } pair_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     edge_valid = 1'b0;
  logic                     edge_stall;
  logic [ecc_pkg::ID_W-1:0] end_a = '0;
  logic [ecc_pkg::ID_W-1:0] end_b = '0;
  logic                     last_edge = 1'b0;
  logic                     result_valid;
  logic                     result_stall = 1'b0;
  logic                     cycle_found;

  edge_set_cycle_check DUT (
    .clk          (clk),
    .rst          (rst),
    .edge_valid   (edge_valid),
    .edge_stall   (edge_stall),
    .end_a        (end_a),
    .end_b        (end_b),
    .last_edge    (last_edge),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cycle_found  (cycle_found)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predicted slot table of the set in progress.
  logic [ecc_pkg::ID_W-1:0]   node_id  [ecc_pkg::SLOT_MAX];
  logic [ecc_pkg::DEG_W-1:0]  node_deg [ecc_pkg::SLOT_MAX];
  logic [ecc_pkg::SLOT_W-1:0] node_nbr [ecc_pkg::SLOT_MAX][2];
  int                         nodes_used;
  int                         pairs_taken;
  bit                         deg_over;

  bit    loop_verdicts [$];
  pair_t pending_pairs [$];
  pair_t set_buf [$];

  int    total_pairs;
  int    pairs_sent = 0;
  int    verdicts_due = 0;
  int    verdicts_seen = 0;
  int    misses = 0;
  int    cycle_n = 0;

  function automatic void clear_table();
    for (int i = 0; i < ecc_pkg::SLOT_MAX; i++) begin
      node_id[i]     = '0;
      node_deg[i]    = ecc_pkg::DEG_ZERO;
      node_nbr[i][0] = '0;
      node_nbr[i][1] = '0;
    end
    nodes_used  = 0;
    pairs_taken = 0;
    deg_over    = 1'b0;
  endfunction

  function automatic int slot_for(logic [ecc_pkg::ID_W-1:0] id);
    for (int i = 0; i < nodes_used; i++)
      if (node_id[i] == id) return i;
    if (nodes_used < ecc_pkg::SLOT_MAX) begin
      node_id[nodes_used]  = id;
      node_deg[nodes_used] = ecc_pkg::DEG_ZERO;
      nodes_used++;
      return nodes_used - 1;
    end
    return ecc_pkg::SLOT_MAX - 1;
  endfunction

  // Cycle verdict of the finished set: an overflowed or all-degree-two set counts as one;
  // else walk each path from a degree-one end, any degree-two node left unvisited lies on a cycle.
  function automatic bit loop_verdict();
    logic [ecc_pkg::DEG_W-1:0] d [ecc_pkg::SLOT_MAX];
    int start, prev, nxt, here;
    bit all_two;
    if (deg_over) return 1'b1;
    all_two = 1'b1;
    for (int i = 0; i < nodes_used; i++)
      if (node_deg[i] != ecc_pkg::DEG_TWO) all_two = 1'b0;
    if (all_two) return 1'b1;
    d = node_deg;
    for (int i = 0; i < nodes_used; i++) begin
      if (d[i] != ecc_pkg::DEG_ONE) continue;
      start = i;
      prev  = i;
      nxt   = node_nbr[i][0];
      d[i]  = ecc_pkg::DEG_ZERO;
      while (nxt != start && d[nxt] == ecc_pkg::DEG_TWO) begin
        here    = nxt;
        d[here] = ecc_pkg::DEG_ZERO;
        if (node_nbr[here][0] == prev) nxt = node_nbr[here][1];
        else nxt = node_nbr[here][0];
        prev = here;
      end
      if (nxt == start) return 1'b1;
      d[nxt] = ecc_pkg::DEG_ZERO;
    end
    for (int i = 0; i < nodes_used; i++)
      if (d[i] == ecc_pkg::DEG_TWO) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void take_pair(pair_t p);
    int sa, sb;
    if (!deg_over && pairs_taken < ecc_pkg::MAX_EDGES) begin
      pairs_taken++;
      sa = slot_for(p.a);
      sb = slot_for(p.b);
      if (sa == sb) begin
        if (node_deg[sa] != ecc_pkg::DEG_ZERO) begin
          deg_over = 1'b1;
        end else begin
          node_nbr[sa][0] = ecc_pkg::SLOT_W'(sa);
          node_nbr[sa][1] = ecc_pkg::SLOT_W'(sa);
          node_deg[sa]    = ecc_pkg::DEG_TWO;
        end
      end else if (node_deg[sa] > ecc_pkg::DEG_ONE || node_deg[sb] > ecc_pkg::DEG_ONE) begin
        deg_over = 1'b1;
      end else begin
        node_nbr[sa][node_deg[sa]] = ecc_pkg::SLOT_W'(sb);
        node_deg[sa]++;
        node_nbr[sb][node_deg[sb]] = ecc_pkg::SLOT_W'(sa);
        node_deg[sb]++;
      end
    end
    if (p.last) begin
      loop_verdicts.push_back(loop_verdict());
      clear_table();
    end
  endfunction

  function automatic void add_link(logic [ecc_pkg::ID_W-1:0] a, logic [ecc_pkg::ID_W-1:0] b);
    set_buf.push_back('{a: a, b: b, last: 1'b0, hold: 1'b0});
  endfunction

  function automatic logic [ecc_pkg::ID_W-1:0] pool_id();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return ecc_pkg::ID_W'($urandom);
    endcase
  endfunction

  // Mark the set's last word, optionally shuffle order and orientation, queue it.
  function automatic void close_set(bit hold, bit mix);
    pair_t tmp;
    int j;
    logic [ecc_pkg::ID_W-1:0] t;
    if (mix) begin
      for (int i = set_buf.size() - 1; i > 0; i--) begin
        j          = $urandom_range(0, i);
        tmp        = set_buf[i];
        set_buf[i] = set_buf[j];
        set_buf[j] = tmp;
      end
      foreach (set_buf[i])
        if ($urandom_range(0, 1) == 1) begin
          t            = set_buf[i].a;
          set_buf[i].a = set_buf[i].b;
          set_buf[i].b = t;
        end
    end
    set_buf[0].hold               = hold;
    set_buf[set_buf.size()-1].last = 1'b1;
    foreach (set_buf[i]) pending_pairs.push_back(set_buf[i]);
    set_buf.delete();
  endfunction

  // Disjoint paths and cycles with fresh random ids, target edges in all.
  function automatic void grow_graph(int target);
    int left, k;
    bit ring;
    logic [ecc_pkg::ID_W-1:0] first, prev, nxt;
    left = target;
    while (left > 0) begin
      k     = $urandom_range(1, left);
      ring  = $urandom_range(0, 1);
      first = ecc_pkg::ID_W'($urandom);
      prev  = first;
      if (ring && k == 1) begin
        add_link(first, first);
      end else if (ring && k == 2) begin
        nxt = ecc_pkg::ID_W'($urandom);
        add_link(first, nxt);
        add_link(nxt, first);
      end else begin
        for (int j = 0; j < k; j++) begin
          nxt = (ring && j == k - 1) ? first : ecc_pkg::ID_W'($urandom);
          add_link(prev, nxt);
          prev = nxt;
        end
      end
      left -= k;
    end
  endfunction

  initial begin
    logic [ecc_pkg::ID_W-1:0] pool [6];
    logic [ecc_pkg::ID_W-1:0] hub;
    int r, n, psize;
    bit held_mid;

    clear_table();

    add_link('0, '1);
    close_set(1'b0, 1'b0);
    add_link(24'h5A5A5A, 24'h5A5A5A);
    close_set(1'b0, 1'b0);
    // same pair twice: two-node cycle
    add_link(24'h000011, 24'h000022);
    add_link(24'h000022, 24'h000011);
    close_set(1'b0, 1'b0);
    add_link(24'h000011, 24'h000022);
    add_link(24'h000022, 24'h000033);
    add_link(24'h000033, 24'h000011);
    close_set(1'b0, 1'b0);
    add_link(24'h000033, 24'h000044);
    add_link(24'h000011, 24'h000022);
    add_link(24'h000022, 24'h000033);
    close_set(1'b0, 1'b0);
    // self loop on a used node overflows, then the rest is dropped
    add_link(24'h000011, 24'h000022);
    add_link(24'h000022, 24'h000022);
    add_link(24'h000033, 24'h000044);
    close_set(1'b0, 1'b0);
    add_link(24'hABCDEF, 24'h000001);
    add_link(24'hABCDEF, 24'h000002);
    add_link(24'hABCDEF, 24'h000003);
    close_set(1'b0, 1'b0);
    // path of MAX_EDGES, the closing pair beyond the limit is dropped
    for (int i = 0; i < ecc_pkg::MAX_EDGES; i++)
      add_link(ecc_pkg::ID_W'(i * 24'h111111), ecc_pkg::ID_W'((i + 1) * 24'h111111));
    add_link(ecc_pkg::ID_W'(ecc_pkg::MAX_EDGES * 24'h111111), '0);
    close_set(1'b0, 1'b0);

    held_mid = 1'b0;
    psize = pending_pairs.size();
    while (pending_pairs.size() < 650) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        grow_graph($urandom_range(1, ecc_pkg::MAX_EDGES));
      end else if (r < 75) begin
        grow_graph(ecc_pkg::MAX_EDGES);
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) add_link(pool_id(), pool_id());
      end else if (r < 87) begin
        foreach (pool[i]) pool[i] = pool_id();
        n = $urandom_range(1, ecc_pkg::MAX_EDGES + 1);
        for (int i = 0; i < n; i++)
          add_link(pool[$urandom_range(0, 5)], pool[$urandom_range(0, 5)]);
      end else begin
        // broken set: one node pushed past degree two
        grow_graph($urandom_range(2, 6));
        hub = set_buf[$urandom_range(0, set_buf.size() - 1)].a;
        add_link(hub, ecc_pkg::ID_W'($urandom));
        add_link(ecc_pkg::ID_W'($urandom), hub);
      end
      close_set(pending_pairs.size() == psize ||
                (!held_mid && pending_pairs.size() > 400), 1'b1);
      if (pending_pairs.size() > 400) held_mid = 1'b1;
    end
    total_pairs = pending_pairs.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pairs_sent != total_pairs || verdicts_seen != verdicts_due) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (misses == 0 && loop_verdicts.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Sender: bursts of words with random gaps; a held word waits for a full drain.
  pair_t shown = '{a: '0, b: '0, last: 1'b0, hold: 1'b0};
  int    burst_left = 1;
  int    gap_left = 0;
  int    due_now;

  always @(posedge clk) begin
    if (rst) begin
      edge_valid <= 1'b0;
    end else begin
      due_now = verdicts_due;
      if (edge_valid && !edge_stall) begin
        take_pair(shown);
        pairs_sent <= pairs_sent + 1;
        if (shown.last) begin
          verdicts_due <= verdicts_due + 1;
          due_now = verdicts_due + 1;
        end
      end
      if (!edge_valid || !edge_stall) begin
        if (gap_left > 0) begin
          gap_left   <= gap_left - 1;
          edge_valid <= 1'b0;
        end else if (pending_pairs.size() != 0 &&
                     !(pending_pairs[0].hold && due_now != verdicts_seen)) begin
          shown      <= pending_pairs[0];
          end_a      <= pending_pairs[0].a;
          end_b      <= pending_pairs[0].b;
          last_edge  <= pending_pairs[0].last;
          edge_valid <= 1'b1;
          void'(pending_pairs.pop_front());
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 16);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          edge_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern changes mode now and then, with one long hold-off.
  int rx_cycles = 0;
  int mode_left = 0;
  int rx_mode = 0;
  bit want;

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      rx_cycles <= rx_cycles + 1;
      if (result_valid && !result_stall) begin
        verdicts_seen <= verdicts_seen + 1;
        if (loop_verdicts.size() == 0) begin
          misses++;
          if (misses <= 10)
            $display("unexpected result word: cycle_found=%0b", cycle_found);
        end else begin
          want = loop_verdicts.pop_front();
          if (cycle_found !== want) begin
            misses++;
            if (misses <= 10)
              $display("cycle_found mismatch: expected %0b, got %0b", want, cycle_found);
          end
        end
      end
      if (rx_cycles >= HOLD_START && rx_cycles < HOLD_START + HOLD_LEN) begin
        result_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          rx_mode   <= $urandom_range(0, 2);
          mode_left <= $urandom_range(32, 200);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (rx_mode)
          0:       result_stall <= 1'b0;
          1:       result_stall <= ($urandom_range(0, 3) == 0);
          default: result_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n == LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule
